>>> hdl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared types and constants for the Cartesian to spherical converter:
// angle accumulator format, arctangent table and angle limits.
// ----------------------------------------------------------------------------
package c2s_pkg;

  // Angle accumulator, Q2.30 radians with headroom for pre-rotation by pi
  localparam int ACC_W = 35;
  // Angle after rounding to Q3.13, before clamping
  localparam int Q13_W = ACC_W - 17;
  localparam int AZ_W  = 16;
  localparam int ZEN_W = 15;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [Q13_W-1:0] q13_t;

  localparam acc_t PI_Q30    = 35'sd3373259426;
  localparam acc_t ROUND_Q13 = 35'sd65536;
  localparam q13_t PI_Q13    = 18'sd25736;
  localparam logic [ZEN_W-1:0] ZEN_PI = 15'd25736;

  // atan(2^-i) * 2^30, truncated
  localparam acc_t ATAN_Q30 [32] = '{
    35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
    35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
    35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
    35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
    35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
    35'sd1023,      35'sd511,       35'sd255,       35'sd127,
    35'sd63,        35'sd31,        35'sd15,        35'sd7,
    35'sd3,         35'sd1,         35'sd0,         35'sd0
  };

endpackage

>>> hdl/c2s_delay.sv
// ----------------------------------------------------------------------------
// c2s_delay
// Enabled shift line that keeps side data aligned with the main pipeline.
// ----------------------------------------------------------------------------
module c2s_delay #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

>>> hdl/c2s_sqrt.sv
// ----------------------------------------------------------------------------
// c2s_sqrt
// Pipelined integer square root, one root bit per stage, with remainder.
// ----------------------------------------------------------------------------
module c2s_sqrt #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           valid_in,
  input  logic [2*N-1:0] value,
  output logic           valid_out,
  output logic [N-1:0]   root,
  output logic [N:0]     rem
);

  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] rem_q  [N];
  logic           vld_q  [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;
    logic [N-1:0]   root_prev;
    logic [2*N-1:0] rem_prev;
    logic           vld_prev;
    logic [2*N:0]   trial;
    logic           fits;

    if (j == 0) begin : g_first
      assign root_prev = '0;
      assign rem_prev  = value;
      assign vld_prev  = valid_in;
    end else begin : g_next
      assign root_prev = root_q[j-1];
      assign rem_prev  = rem_q[j-1];
      assign vld_prev  = vld_q[j-1];
    end

    // (2r + 2^k) * 2^k; bits of r sit above k so the terms never overlap
    assign trial = ((2*N+1)'(root_prev) << (K + 1)) | ((2*N+1)'(1) << (2 * K));
    assign fits  = {1'b0, rem_prev} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[j] <= root_prev | (N'(fits) << K);
        rem_q[j]  <= fits ? rem_prev - trial[2*N-1:0] : rem_prev;
      end
    end
  end

  assign valid_out = vld_q[N-1];
  assign root      = root_q[N-1];
  assign rem       = rem_q[N-1][N:0];

endmodule

>>> hdl/c2s_cordic.sv
// ----------------------------------------------------------------------------
// c2s_cordic
// Pipelined CORDIC vectoring: atan2(b, a) in Q2.30 radians, one
// micro-rotation per stage after a quadrant pre-rotation stage.
// ----------------------------------------------------------------------------
module c2s_cordic #(
  parameter int DW    = 34,
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic signed [DW-1:0] a_in,
  input  logic signed [DW-1:0] b_in,
  output logic                 valid_out,
  output c2s_pkg::acc_t        angle
);

  logic signed [DW-1:0] a_q   [STEPS];
  logic signed [DW-1:0] b_q   [STEPS];
  c2s_pkg::acc_t        acc_q [STEPS+1];
  logic                 vld_q [STEPS+1];
  logic                 frc_q [STEPS+1];   // b was zero: angle is fixed
  logic                 fpi_q [STEPS+1];   // fixed angle is pi

  logic b_zero;
  logic a_neg;

  assign b_zero = (b_in == '0);
  assign a_neg  = a_in[DW-1];

  // pre-rotation: negative a turns the vector by pi towards the b sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frc_q[0] <= b_zero;
      fpi_q[0] <= a_neg;
      if (a_neg && !b_zero) begin
        a_q[0]   <= -a_in;
        b_q[0]   <= -b_in;
        acc_q[0] <= b_in[DW-1] ? -c2s_pkg::PI_Q30 : c2s_pkg::PI_Q30;
      end else begin
        a_q[0]   <= a_in;
        b_q[0]   <= b_in;
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        frc_q[i+1] <= frc_q[i];
        fpi_q[i+1] <= fpi_q[i];
        acc_q[i+1] <= b_q[i][DW-1] ? acc_q[i] - c2s_pkg::ATAN_Q30[i]
                                   : acc_q[i] + c2s_pkg::ATAN_Q30[i];
      end
    end

    if (i < STEPS - 1) begin : g_rot
      logic signed [DW-1:0] da;
      logic signed [DW-1:0] db;

      assign da = b_q[i] >>> i;
      assign db = a_q[i] >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          if (b_q[i][DW-1]) begin
            a_q[i+1] <= a_q[i] - da;
            b_q[i+1] <= b_q[i] + db;
          end else begin
            a_q[i+1] <= a_q[i] + da;
            b_q[i+1] <= b_q[i] - db;
          end
        end
      end
    end
  end

  assign valid_out = vld_q[STEPS];
  assign angle     = frc_q[STEPS] ? (fpi_q[STEPS] ? c2s_pkg::PI_Q30 : '0)
                                  : acc_q[STEPS];

endmodule

>>> hdl/cartesian_to_spherical_core.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_core
// Converts a Cartesian point to radius, azimuth atan2(y, x) and zenith
// atan2(sqrt(x^2 + y^2), z); both angles in Q3.13 radians.
// ----------------------------------------------------------------------------
//
// Channel  Signals                        Dir  Payload
// -------  -----------------------------  ---  ------------------------------
// point    point_valid / point_ready      in   coord_x, coord_y, coord_z
// result   result_valid / result_ready    out  radius, azimuth_angle,
//                                              zenith_angle
//
// One point per cycle sustained unless the result side stalls. The path from
// transfer in to result valid is set by the lateral square root (one root bit
// per stage) followed by the zenith CORDIC.
// Reset clears every valid bit; payload registers are left alone.
// A stalled result parks in a one-entry skid register; the whole pipeline
// then holds, and point_ready comes straight from a flop.
//
module cartesian_to_spherical_core #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            point_valid,
  output logic                            point_ready,
  input  logic signed [COORD_WIDTH-1:0]   coord_x,
  input  logic signed [COORD_WIDTH-1:0]   coord_y,
  input  logic signed [COORD_WIDTH-1:0]   coord_z,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [COORD_WIDTH-1:0]          radius,
  output logic signed [c2s_pkg::AZ_W-1:0] azimuth_angle,
  output logic [c2s_pkg::ZEN_W-1:0]       zenith_angle
);

  localparam int CW    = COORD_WIDTH;
  // fraction bits that lift the CORDIC operands to about 31 bits
  localparam int FRAC  = (CW < 31) ? 31 - CW : 0;
  localparam int N_RHO = CW + FRAC;          // root bits of the lateral length
  localparam int DW    = N_RHO + 3;          // CORDIC datapath, covers gain
  localparam int RAD_DLY = N_RHO - CW + ANGLE_STEPS + 1;

  // --------------------------------------------------------------------------
  // Flow control: the pipeline moves unless the skid register is occupied
  // --------------------------------------------------------------------------
  logic pipe_en;
  logic skid_valid;

  assign pipe_en     = !skid_valid;
  assign point_ready = pipe_en;

  // --------------------------------------------------------------------------
  // Front end: capture, squares, sums
  // --------------------------------------------------------------------------
  logic                   v0, v1, v2;
  logic signed [CW-1:0]   x0, y0, z0;
  logic signed [CW-1:0]   x1, y1, z1;
  logic signed [CW-1:0]   x2, y2, z2;
  logic [2*CW-1:0]        sq_x, sq_y, sq_z;
  logic [2*CW-1:0]        lat2;          // x^2 + y^2
  logic [2*CW-1:0]        sum2;          // x^2 + y^2 + z^2

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (pipe_en) begin
      v0 <= point_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      x0   <= coord_x;
      y0   <= coord_y;
      z0   <= coord_z;
      x1   <= x0;
      y1   <= y0;
      z1   <= z0;
      sq_x <= x0 * x0;
      sq_y <= y0 * y0;
      sq_z <= z0 * z0;
      x2   <= x1;
      y2   <= y1;
      z2   <= z1;
      lat2 <= sq_x + sq_y;
      sum2 <= sq_x + sq_y + sq_z;
    end
  end

  // --------------------------------------------------------------------------
  // Square roots: radius (rounded later) and lateral length with fraction
  // --------------------------------------------------------------------------
  logic             rad_vld;
  logic [CW-1:0]    rad_root;
  logic [CW:0]      rad_rem;
  logic [CW-1:0]    rad_rnd;
  logic [CW-1:0]    rad_d;
  logic             rho_valid;
  logic [N_RHO-1:0] rho;
  logic [N_RHO:0]   rho_rem;

  c2s_sqrt #(.N(CW)) u_rad_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .valid_in  (v2),
    .value     (sum2),
    .valid_out (rad_vld),
    .root      (rad_root),
    .rem       (rad_rem)
  );

  c2s_sqrt #(.N(N_RHO)) u_rho_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .valid_in  (v2),
    .value     ((2*N_RHO)'(lat2) << (2 * FRAC)),
    .valid_out (rho_valid),
    .root      (rho),
    .rem       (rho_rem)
  );

  // round half up: bump when the remainder exceeds the floor root
  assign rad_rnd = rad_root + CW'(rad_rem > {1'b0, rad_root});

  c2s_delay #(.WIDTH(CW), .DEPTH(RAD_DLY)) u_rad_dly (
    .clk (clk),
    .en  (pipe_en),
    .d   (rad_rnd),
    .q   (rad_d)
  );

  // coordinates wait for the lateral root
  logic [3*CW-1:0]      xyz_d;
  logic signed [CW-1:0] xd, yd, zd;

  c2s_delay #(.WIDTH(3 * CW), .DEPTH(N_RHO)) u_xyz_dly (
    .clk (clk),
    .en  (pipe_en),
    .d   ({x2, y2, z2}),
    .q   (xyz_d)
  );

  assign xd = xyz_d[3*CW-1:2*CW];
  assign yd = xyz_d[2*CW-1:CW];
  assign zd = xyz_d[CW-1:0];

  // --------------------------------------------------------------------------
  // Angles: two CORDIC pipelines side by side
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] xs, ys, zs, rho_s;
  logic                 az_vld, zen_vld;
  c2s_pkg::acc_t        az_acc, zen_acc;

  assign xs    = {{(DW-CW){xd[CW-1]}}, xd} <<< FRAC;
  assign ys    = {{(DW-CW){yd[CW-1]}}, yd} <<< FRAC;
  assign zs    = {{(DW-CW){zd[CW-1]}}, zd} <<< FRAC;
  assign rho_s = {{(DW-N_RHO){1'b0}}, rho};

  c2s_cordic #(.DW(DW), .STEPS(ANGLE_STEPS)) u_az_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .valid_in  (rho_valid),
    .a_in      (xs),
    .b_in      (ys),
    .valid_out (az_vld),
    .angle     (az_acc)
  );

  c2s_cordic #(.DW(DW), .STEPS(ANGLE_STEPS)) u_zen_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .valid_in  (rho_valid),
    .a_in      (zs),
    .b_in      (rho_s),
    .valid_out (zen_vld),
    .angle     (zen_acc)
  );

  // --------------------------------------------------------------------------
  // Q3.13 rounding and clamping
  // --------------------------------------------------------------------------
  function automatic c2s_pkg::q13_t to_q13(input c2s_pkg::acc_t acc);
    c2s_pkg::acc_t t;
    t = acc + c2s_pkg::ROUND_Q13;
    return t[c2s_pkg::ACC_W-1:17];
  endfunction

  c2s_pkg::q13_t az_q, zen_q, az_c, zen_c;

  always_comb begin
    az_q  = to_q13(az_acc);
    zen_q = to_q13(zen_acc);
    az_c  = az_q;
    zen_c = zen_q;
    if (az_q < -c2s_pkg::PI_Q13) begin
      az_c = -c2s_pkg::PI_Q13;
    end else if (az_q > c2s_pkg::PI_Q13) begin
      az_c = c2s_pkg::PI_Q13;
    end
    if (zen_q < 0) begin
      zen_c = '0;
    end else if (zen_q > c2s_pkg::PI_Q13) begin
      zen_c = c2s_pkg::PI_Q13;
    end
  end

  logic                            pv;
  logic [CW-1:0]                   pd_rad;
  logic signed [c2s_pkg::AZ_W-1:0] pd_az;
  logic [c2s_pkg::ZEN_W-1:0]       pd_zen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (pipe_en) begin
      pv <= zen_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pd_rad <= rad_d;
      pd_az  <= az_c[c2s_pkg::AZ_W-1:0];
      pd_zen <= zen_c[c2s_pkg::ZEN_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register with one-entry skid
  // --------------------------------------------------------------------------
  logic [CW-1:0]                   skid_rad;
  logic signed [c2s_pkg::AZ_W-1:0] skid_az;
  logic [c2s_pkg::ZEN_W-1:0]       skid_zen;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_ready || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= pv;
      end
    end else if (pv && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ready || !result_valid) begin
      if (skid_valid) begin
        radius        <= skid_rad;
        azimuth_angle <= skid_az;
        zenith_angle  <= skid_zen;
      end else begin
        radius        <= pd_rad;
        azimuth_angle <= pd_az;
        zenith_angle  <= pd_zen;
      end
    end else if (!skid_valid) begin
      skid_rad <= pd_rad;
      skid_az  <= pd_az;
      skid_zen <= pd_zen;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cordic_lockstep: assert property (@(posedge clk) disable iff (rst)
    az_vld == zen_vld)
    else $error("azimuth and zenith pipelines out of step");

  a_root_lockstep: assert property (@(posedge clk) disable iff (rst)
    rad_vld == u_rho_sqrt.vld_q[CW-1])
    else $error("radius and lateral roots out of step");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held while output register empty");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> pv == $past(pv))
    else $error("pipeline moved while skid register full");

  a_zenith_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> zenith_angle <= c2s_pkg::ZEN_PI)
    else $error("zenith beyond pi");

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cartesian_to_spherical_core. Points go in over a
// valid/ready channel and each one is predicted in the bench with a
// bit-accurate copy of the fixed-point conversion: an integer square root and
// CORDIC vectoring in 64-bit arithmetic. Results are checked in order, field
// by field. The stimulus runs through directed corner points, a long receiver
// hold-off and three random phases with different idle patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W            = 16;
  localparam int FRAC         = 31 - W;       // operand scaling inside the CORDIC
  localparam int STEPS        = 16;           // micro-rotations per angle
  localparam int CYCLE_LIMIT  = 200000;       // hard stop, far above a slow run
  localparam int LONG_HOLD    = 400;          // receiver hold-off, in cycles
  localparam int DRAIN_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 80;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint PI_Q13 = 64'sd25736;

  // atan(2^-i) in Q2.30, truncated
  localparam longint ARCTAN_STEP [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1, 0, 0
  };

  localparam logic signed [W-1:0] EXTREME_COORDS [6] = '{
    -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
  };

  typedef struct packed {
    logic [W-1:0]                    rad;
    logic signed [c2s_pkg::AZ_W-1:0] azi;
    logic [c2s_pkg::ZEN_W-1:0]       zen;
  } spherical_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // point channel
  logic                point_valid = 1'b0;
  logic                point_ready;
  logic signed [W-1:0] coord_x = '0;
  logic signed [W-1:0] coord_y = '0;
  logic signed [W-1:0] coord_z = '0;

  // result channel
  logic                            result_valid;
  logic                            result_ready = 1'b0;
  logic [W-1:0]                    radius;
  logic signed [c2s_pkg::AZ_W-1:0] azimuth_angle;
  logic [c2s_pkg::ZEN_W-1:0]       zenith_angle;

  // Predicted results, oldest first
  spherical_t expected_spherical [$];

  int cycle         = 0;
  int mismatches    = 0;
  int send_idle_pct = 0;   // chance in a hundred that the sender skips a cycle
  int recv_idle_pct = 0;   // same for the receiver
  int holds_asked   = 0;   // bumped by a test to ask for a long hold-off
  int holds_granted = 0;

  cartesian_to_spherical_core #(
    .COORD_WIDTH (W),
    .ANGLE_STEPS (STEPS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .point_valid   (point_valid),
    .point_ready   (point_ready),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .radius        (radius),
    .azimuth_angle (azimuth_angle),
    .zenith_angle  (zenith_angle)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  // Hard stop in case the pipeline locks up or results go missing
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             expected_spherical.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Bitwise integer square root, floor
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // atan2(b, a) in Q2.30 by CORDIC vectoring; exact answers when b is zero,
  // pre-rotation by pi when a is negative
  function automatic longint vector_angle(input longint b, input longint a);
    longint acc;
    longint da;
    longint db;
    acc = 0;
    if (b == 0) return (a < 0) ? PI_Q30 : 64'sd0;
    if (a < 0) begin
      acc = (b > 0) ? PI_Q30 : -PI_Q30;
      a   = -a;
      b   = -b;
    end
    for (int i = 0; i < STEPS; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a   += da;
        b   -= db;
        acc += ARCTAN_STEP[i];
      end else begin
        a   -= da;
        b   += db;
        acc -= ARCTAN_STEP[i];
      end
    end
    return acc;
  endfunction

  // Q2.30 to Q3.13, rounded half up, then clamped
  function automatic longint round_q13(input longint q30, input longint lo,
                                       input longint hi);
    longint v;
    v = (q30 + 64'sd65536) >>> 17;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic spherical_t predict_spherical(input logic signed [W-1:0] x,
                                                   input logic signed [W-1:0] y,
                                                   input logic signed [W-1:0] z);
    longint          sx;
    longint          sy;
    longint          sz;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned az;
    longint unsigned lat2;
    longint unsigned sum2;
    longint unsigned root;
    longint          rho;
    longint          azi;
    longint          zen;
    spherical_t      res;
    sx   = x;
    sy   = y;
    sz   = z;
    ax   = (sx < 0) ? -sx : sx;
    ay   = (sy < 0) ? -sy : sy;
    az   = (sz < 0) ? -sz : sz;
    lat2 = ax * ax + ay * ay;
    sum2 = lat2 + az * az;
    root = floor_sqrt(sum2);
    if (sum2 - root * root > root) root += 1;
    if (sum2 == 0) return '0;
    rho = floor_sqrt(lat2 << (2 * FRAC));
    azi = round_q13(vector_angle(sy * (64'sd1 << FRAC), sx * (64'sd1 << FRAC)),
                    -PI_Q13, PI_Q13);
    zen = round_q13(vector_angle(rho, sz * (64'sd1 << FRAC)), 0, PI_Q13);
    res.rad = root[W-1:0];
    res.azi = azi[c2s_pkg::AZ_W-1:0];
    res.zen = zen[c2s_pkg::ZEN_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input longint got,
                               input longint want);
    $display("[cycle %0d] %s: got %0d, expected %0d", cycle, what, got, want);
    mismatches++;
  endtask

  // All DUT outputs move on clock edges only, so at the edge we see the values
  // that the transfer itself used
  always @(posedge clk) begin : result_check
    spherical_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_spherical.size() == 0) begin
        note_mismatch("result with no point outstanding", radius, 0);
      end else begin
        want = expected_spherical.pop_front();
        if (radius !== want.rad) note_mismatch("radius", radius, want.rad);
        if (azimuth_angle !== want.azi)
          note_mismatch("azimuth", azimuth_angle, want.azi);
        if (zenith_angle !== want.zen)
          note_mismatch("zenith", zenith_angle, want.zen);
      end
    end
  end

  // Receiver: random ready, or a long hold-off when a test asks for one
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (holds_granted != holds_asked) begin
        holds_granted = holds_asked;
        result_ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offers one point and returns at the edge where it transfers. Valid is only
  // dropped when an idle gap is drawn, so back-to-back points keep it high.
  task automatic send_point(input logic signed [W-1:0] x,
                            input logic signed [W-1:0] y,
                            input logic signed [W-1:0] z);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    expected_spherical.push_back(predict_spherical(x, y, z));
    do @(posedge clk); while (!point_ready);
  endtask

  // Mostly full-range values, with zeros, extremes and small magnitudes mixed
  // in so the axis and sign special cases keep turning up
  function automatic logic signed [W-1:0] pick_coord();
    int k;
    k = $urandom_range(9);
    case (k)
      0:       pick_coord = '0;
      1:       pick_coord = EXTREME_COORDS[$urandom_range(5)];
      2, 3:    pick_coord = W'($urandom_range(64)) - W'(32);
      default: pick_coord = W'($urandom);
    endcase
  endfunction

  // Origin, each axis at both ends, the y = 0 and x < 0 branches, the
  // clamp region near +/- pi and the corners of the cube
  task automatic test_corner_points();
    send_point(0, 0, 0);
    send_point(0, 0, 1);
    send_point(0, 0, -1);
    send_point(0, 0, 32767);
    send_point(0, 0, -32768);
    send_point(1, 0, 0);
    send_point(-1, 0, 0);
    send_point(32767, 0, 5);
    send_point(-32768, 0, -7);
    send_point(0, 1, 0);
    send_point(0, -1, 0);
    send_point(0, 32767, 0);
    send_point(0, -32768, 0);
    send_point(-5, 3, 0);
    send_point(-5, -3, 0);
    send_point(-32768, 1, 0);
    send_point(-32768, -1, 0);
    send_point(-32768, -32768, -32768);
    send_point(32767, 32767, 32767);
    send_point(-32768, 32767, -32768);
    send_point(32767, -32768, 1);
    send_point(1, 1, 1);
    send_point(-1, -1, -1);
    send_point(3, 4, 0);
  endtask

  // Receiver holds off while the sender keeps offering: the pipeline and the
  // skid register fill, point_ready drops, then everything drains in order
  task automatic test_result_backpressure();
    holds_asked++;
    for (int n = 0; n < 150; n++) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic test_random_points(input int count);
    for (int n = 0; n < count; n++) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  initial begin : sequencer
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 57;
    test_corner_points();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_result_backpressure();

    send_idle_pct = 32;
    recv_idle_pct = 57;
    test_random_points(192);

    send_idle_pct = 57;
    recv_idle_pct = 32;
    test_random_points(192);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_points(192);

    point_valid <= 1'b0;

    // Let the last results out, then a few more cycles to catch strays
    waited = 0;
    while (expected_spherical.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_spherical.size() != 0)
      note_mismatch("results never delivered", expected_spherical.size(), 0);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
